// ===== src/htg_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, register codes and the sine table builder for the tone generator.
package htg_pkg;

  localparam int PHASE_BITS_DEF      = 32;
  localparam int TABLE_ADDR_BITS_DEF = 10;
  localparam int COUNT_BITS_DEF      = 25;

  localparam int STEP_BITS   = 32;
  localparam int LIMIT_BITS  = 24;
  localparam int FRAME_BITS  = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int AMP_BITS    = 14;
  localparam int REG_IDX_BITS = 2;

  localparam logic [STEP_BITS-1:0]  PHASE_STEP_RST  = 32'd44739243;
  localparam logic [LIMIT_BITS-1:0] FRAME_LIMIT_RST = 24'd30000;

  // Register indexes of the configuration channel
  localparam logic [REG_IDX_BITS-1:0] REG_PHASE_STEP     = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_FRAME_LIMIT    = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_CHANNEL_SELECT = 2'd2;

  // Channel select codes
  localparam logic [1:0] CH_LEFT  = 2'd1;
  localparam logic [1:0] CH_RIGHT = 2'd2;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam logic [63:0] TONE_AMP    = 64'd8191;

  // Quarter-wave sine at step k of 2^qbits steps, Q30 Taylor series in Horner form.
  function automatic logic [AMP_BITS-1:0] quarter_sine(input logic [31:0] k, input int qbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    x  = (64'(k) * Q30_HALF_PI + (64'd1 << (qbits - 1))) >> qbits;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd210;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    r  = (s * TONE_AMP + (64'd1 << 29)) >> 30;
    return r[AMP_BITS-1:0];
  endfunction

endpackage

// ===== src/htg_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces: frame ticks in, samples out, register writes.
interface htg_in_if;
  logic                         valid;
  logic                         ready;
  logic                         buffer_start;
  logic [htg_pkg::FRAME_BITS-1:0] buffer_frames;
  modport source (output valid, output buffer_start, output buffer_frames, input ready);
  modport sink   (input valid, input buffer_start, input buffer_frames, output ready);
endinterface

interface htg_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [htg_pkg::SAMPLE_BITS-1:0] sample_value;
  logic                                 silent;
  logic                                 right_slot;
  modport source (output valid, output sample_value, output silent, output right_slot,
                  input ready);
  modport sink   (input valid, input sample_value, input silent, input right_slot,
                  output ready);
endinterface

interface htg_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [htg_pkg::REG_IDX_BITS-1:0]  reg_index;
  logic [htg_pkg::STEP_BITS-1:0]     reg_data;
  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

// ===== src/harmonic_tone_generator.sv =====
`timescale 1ns / 1ps
// Harmonic tone generator: four-harmonic phase-accumulator sine source.
//
// Usage: every frame tick is one transaction on in_ch; buffer_start marks the
// first tick of a buffer and buffer_frames gives that buffer's length. Each
// tick yields exactly one transaction on out_ch with the summed sample, the
// silent flag and the output slot. Registers (phase step, frame limit,
// channel select) are written on cfg_ch, which is always ready; write them
// only while no tick is in flight.
// A taken tick passes the queue, then the s1, s2, s3 and output registers.
// Throughput: one tick per cycle while out_ch.ready is high, set by the
// pipelined back end (multiply, phase update, table read, sum), one per stage.
// A four-entry queue sits between the front end and the back end. When the
// receiver stalls, the back pipeline holds, the queue fills and in_ch.ready
// drops once it is full; no result is lost or repeated.
// Reset: frame count and phase are cleared, the block is audible, and the
// registers return to their default values.
module harmonic_tone_generator #(
  parameter int PHASE_BITS      = htg_pkg::PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = htg_pkg::TABLE_ADDR_BITS_DEF,
  parameter int COUNT_BITS      = htg_pkg::COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  htg_in_if.sink     in_ch,
  htg_out_if.source  out_ch,
  htg_cfg_if.sink    cfg_ch
);
  import htg_pkg::*;

  logic [STEP_BITS-1:0]  phase_step;
  logic [LIMIT_BITS-1:0] frame_limit;
  logic [1:0]            channel_select;

  logic                  push;
  logic [COUNT_BITS+1:0] push_data;
  logic                  queue_ready;
  logic                  queue_valid;
  logic [COUNT_BITS+1:0] queue_head;
  logic                  pop;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step     <= PHASE_STEP_RST;
      frame_limit    <= FRAME_LIMIT_RST;
      channel_select <= CH_LEFT;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        REG_PHASE_STEP:     phase_step     <= cfg_ch.reg_data;
        REG_FRAME_LIMIT:    frame_limit    <= cfg_ch.reg_data[LIMIT_BITS-1:0];
        REG_CHANNEL_SELECT: channel_select <= cfg_ch.reg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  htg_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .frame_limit (frame_limit),
    .queue_ready (queue_ready),
    .push        (push),
    .push_data   (push_data)
  );

  htg_queue #(
    .WIDTH (COUNT_BITS + 2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .ready     (queue_ready),
    .pop       (pop),
    .not_empty (queue_valid),
    .head      (queue_head)
  );

  htg_back #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .COUNT_BITS      (COUNT_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .queue_valid    (queue_valid),
    .queue_head     (queue_head),
    .pop            (pop),
    .phase_step     (phase_step),
    .channel_select (channel_select),
    .out_ch         (out_ch)
  );

endmodule

// ===== src/htg_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts frame ticks, tracks the frame count and marks buffers silent.
module htg_front #(
  parameter int COUNT_BITS = htg_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  htg_in_if.sink                          in_ch,
  input  logic [htg_pkg::LIMIT_BITS-1:0]  frame_limit,
  input  logic                            queue_ready,
  output logic                            push,
  output logic [COUNT_BITS+1:0]           push_data
);
  import htg_pkg::*;

  localparam int CMP_BITS = ((COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS) + 1;

  logic [COUNT_BITS-1:0] frame_count;
  logic [COUNT_BITS-1:0] frame_count_next;
  logic                  buffer_silent;
  logic                  buffer_silent_next;
  logic                  load;
  logic                  reached;
  logic [COUNT_BITS:0]   count_sum;
  logic [COUNT_BITS-1:0] count_sat;

  assign in_ch.ready = queue_ready;
  assign push        = in_ch.valid && queue_ready;

  assign reached   = CMP_BITS'(frame_count) >= CMP_BITS'(frame_limit);
  assign count_sum = (COUNT_BITS+1)'(frame_count) + (COUNT_BITS+1)'(in_ch.buffer_frames);
  // Saturate at all ones
  assign count_sat = count_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : count_sum[COUNT_BITS-1:0];

  always_comb begin
    frame_count_next   = frame_count;
    buffer_silent_next = buffer_silent;
    load               = 1'b0;
    if (in_ch.buffer_start) begin
      if (reached) begin
        buffer_silent_next = 1'b1;
      end else begin
        frame_count_next   = count_sat;
        buffer_silent_next = 1'b0;
        load               = 1'b1;
      end
    end
  end

  assign push_data = {load, buffer_silent_next, frame_count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count   <= '0;
      buffer_silent <= 1'b0;
    end else if (push) begin
      frame_count   <= frame_count_next;
      buffer_silent <= buffer_silent_next;
    end
  end

endmodule

// ===== src/htg_queue.sv =====
`timescale 1ns / 1ps
// Short queue between the front end and the synthesis back end.
module htg_queue #(
  parameter int WIDTH = htg_pkg::COUNT_BITS_DEF + 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             ready,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);
  import htg_pkg::*;

  localparam int PTR_BITS = 2;
  localparam int DEPTH    = 1 << PTR_BITS;

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0]   level;

  assign ready     = level != (PTR_BITS+1)'(DEPTH);
  assign not_empty = level != '0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

// ===== src/htg_back.sv =====
`timescale 1ns / 1ps
// Back end: phase accumulator, four harmonic table reads and the output register.
module htg_back #(
  parameter int PHASE_BITS      = htg_pkg::PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = htg_pkg::TABLE_ADDR_BITS_DEF,
  parameter int COUNT_BITS      = htg_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           queue_valid,
  input  logic [COUNT_BITS+1:0]          queue_head,
  output logic                           pop,
  input  logic [htg_pkg::STEP_BITS-1:0]  phase_step,
  input  logic [1:0]                     channel_select,
  htg_out_if.source                      out_ch
);
  import htg_pkg::*;

  localparam int QBITS   = TABLE_ADDR_BITS - 2;
  localparam int QUARTER = 1 << QBITS;
  localparam int KBITS   = QBITS + 1;
  localparam int NHARM   = 4;

  // Quarter-wave table, entries 0 through a full quarter turn
  logic [AMP_BITS-1:0] qtab [QUARTER+1];
  for (genvar g = 0; g <= QUARTER; g++) begin : g_qtab
    assign qtab[g] = quarter_sine(32'(g), QBITS);
  end

  logic                  adv;
  logic [PHASE_BITS-1:0] step_p;

  logic                  s1_valid;
  logic                  s1_load;
  logic                  s1_silent;
  logic [PHASE_BITS-1:0] s1_prod;

  logic                  s2_valid;
  logic                  s2_silent;
  logic [PHASE_BITS-1:0] s2_phase;
  logic [PHASE_BITS-1:0] phase_acc;
  logic [PHASE_BITS-1:0] phase_use;

  logic                  s3_valid;
  logic                  s3_silent;
  logic [AMP_BITS-1:0]   s3_mag [NHARM];
  logic                  s3_neg [NHARM];

  logic [AMP_BITS-1:0]   mag_next [NHARM];
  logic                  neg_next [NHARM];
  logic signed [SAMPLE_BITS-1:0] sum_next;

  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          out_silent;
  logic                          out_right;

  // Whole back pipeline moves together; hold when the output is stalled
  assign adv    = !out_valid || out_ch.ready;
  assign pop    = adv && queue_valid;
  assign step_p = PHASE_BITS'(phase_step);

  assign phase_use = s1_load ? s1_prod : phase_acc;

  always_comb begin
    logic [PHASE_BITS-1:0]      ph;
    logic [TABLE_ADDR_BITS-1:0] idx;
    logic [KBITS-1:0]           k;
    for (int h = 0; h < NHARM; h++) begin
      ph  = s2_phase << h;
      idx = ph[PHASE_BITS-1 -: TABLE_ADDR_BITS];
      // Mirror the second and fourth quarters
      if (idx[QBITS]) begin
        k = KBITS'(QUARTER) - KBITS'(idx[QBITS-1:0]);
      end else begin
        k = KBITS'(idx[QBITS-1:0]);
      end
      mag_next[h] = qtab[k];
      neg_next[h] = idx[TABLE_ADDR_BITS-1];
    end
  end

  always_comb begin
    logic signed [SAMPLE_BITS-1:0] v;
    sum_next = '0;
    for (int h = 0; h < NHARM; h++) begin
      v = s3_neg[h] ? -SAMPLE_BITS'(s3_mag[h]) : SAMPLE_BITS'(s3_mag[h]);
      sum_next = sum_next + v;
    end
    if (s3_silent) begin
      sum_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
      phase_acc <= '0;
    end else if (adv) begin
      s1_valid  <= queue_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
      // Advance the phase only for audible ticks
      if (s1_valid && !s1_silent) begin
        phase_acc <= phase_use + step_p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_load    <= queue_head[COUNT_BITS+1];
      s1_silent  <= queue_head[COUNT_BITS];
      s1_prod    <= PHASE_BITS'(queue_head[COUNT_BITS-1:0]) * step_p;
      s2_silent  <= s1_silent;
      s2_phase   <= phase_use;
      s3_silent  <= s2_silent;
      s3_mag     <= mag_next;
      s3_neg     <= neg_next;
      out_sample <= sum_next;
      out_silent <= s3_silent;
      out_right  <= channel_select == CH_RIGHT;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.sample_value = out_sample;
  assign out_ch.silent       = out_silent;
  assign out_ch.right_slot   = out_right;

endmodule

// ===== dv/harmonic_tone_generator_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the harmonic tone generator: directed table, then random buffers.
module harmonic_tone_generator_test;

  localparam int          LUT_SIZE    = 1024;
  localparam int          LUT_QUARTER = LUT_SIZE / 4;
  localparam longint unsigned UNIT_Q30    = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned CNT_MAX     = (64'd1 << 25) - 64'd1;
  localparam int          STALL_LIMIT = 5000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          PHASE_ITEMS = 210;

  typedef struct packed {
    logic signed [15:0] value;
    logic               silent;
    logic               right;
  } tone_result_t;

  typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    bit           start;
    logic [15:0]  frames;
    bit           known;
    tone_result_t want;
    logic [1:0]   reg_idx;
    logic [31:0]  reg_data;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  htg_in_if  in_ch ();
  htg_out_if out_ch ();
  htg_cfg_if cfg_ch ();

  harmonic_tone_generator dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Tone model state
  int              sine_lut [LUT_SIZE];
  longint unsigned tone_cnt;
  logic [31:0]     tone_phase;
  bit              tone_muted;
  logic [31:0]     reg_step;
  logic [23:0]     reg_limit;
  logic [1:0]      reg_sel;

  tone_result_t sample_queue [$];
  stim_row_t    dir_rows [$];
  int           fail_count  = 0;
  int           idle_cycles = 0;
  int           hold_left   = 0;
  bit           hold_request = 1'b0;
  bit           hold_done    = 1'b0;
  bit           gaps_on      = 1'b1;

  function automatic int qwave(int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    x  = (64'(k) * HALF_PI_Q30 + 64'(LUT_QUARTER / 2)) / 64'(LUT_QUARTER);
    x2 = (x * x) >> 30;
    t  = UNIT_Q30;
    for (int n = 7; n >= 1; n--) begin
      t = UNIT_Q30 - ((x2 * t) >> 30) / 64'((2 * n) * (2 * n + 1));
    end
    s = (x * t) >> 30;
    return int'((s * 64'd8191 + (64'd1 << 29)) >> 30);
  endfunction

  function automatic void build_sine_lut();
    int q;
    int r;
    int v;
    for (int i = 0; i < LUT_SIZE; i++) begin
      q = i / LUT_QUARTER;
      r = i % LUT_QUARTER;
      v = (q == 0 || q == 2) ? qwave(r) : qwave(LUT_QUARTER - r);
      sine_lut[i] = (q >= 2) ? -v : v;
    end
  endfunction

  function automatic int sine_at(logic [31:0] ph);
    return sine_lut[ph[31:22]];
  endfunction

  function automatic tone_result_t predict_tone(bit st, logic [15:0] fr);
    longint unsigned c;
    int              sum;
    tone_result_t    r;
    sum = 0;
    if (st) begin
      if (tone_cnt >= 64'(reg_limit)) begin
        tone_muted = 1'b1;
      end else begin
        c = tone_cnt + 64'(fr);
        tone_cnt   = (c > CNT_MAX) ? CNT_MAX : c;
        tone_muted = 1'b0;
        tone_phase = 32'(tone_cnt * 64'(reg_step));
      end
    end
    if (!tone_muted) begin
      sum = sine_at(tone_phase) + sine_at(tone_phase << 1)
          + sine_at(tone_phase << 2) + sine_at(tone_phase << 3);
      tone_phase = tone_phase + reg_step;
    end
    r.value  = 16'(sum);
    r.silent = tone_muted;
    r.right  = (reg_sel == htg_pkg::CH_RIGHT);
    return r;
  endfunction

  function automatic void flag_error(string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic stim_row_t tick_row(bit st, logic [15:0] fr);
    stim_row_t row;
    row.kind     = ROW_TICK;
    row.start    = st;
    row.frames   = fr;
    row.known    = 1'b0;
    row.want     = '0;
    row.reg_idx  = '0;
    row.reg_data = '0;
    return row;
  endfunction

  function automatic stim_row_t known_row(bit st, logic [15:0] fr, logic signed [15:0] v,
                                          logic sil, logic rs);
    stim_row_t row;
    row             = tick_row(st, fr);
    row.known       = 1'b1;
    row.want.value  = v;
    row.want.silent = sil;
    row.want.right  = rs;
    return row;
  endfunction

  function automatic stim_row_t reg_row(logic [1:0] idx, logic [31:0] data);
    stim_row_t row;
    row          = tick_row(1'b0, '0);
    row.kind     = ROW_REG;
    row.reg_idx  = idx;
    row.reg_data = data;
    return row;
  endfunction

  // Leaves valid high; the caller drops it after the last tick of a run.
  task automatic send_tick(bit st, logic [15:0] fr, bit known, tone_result_t want);
    tone_result_t r;
    while (gaps_on && $urandom_range(99) < 8) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.buffer_start  <= st;
    in_ch.buffer_frames <= fr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = predict_tone(st, fr);
    sample_queue.push_back(known ? want : r);
  endtask

  // Leaves valid high; the caller drops it after the last write of a batch.
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.reg_data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      htg_pkg::REG_PHASE_STEP:     reg_step  = data;
      htg_pkg::REG_FRAME_LIMIT:    reg_limit = data[23:0];
      htg_pkg::REG_CHANNEL_SELECT: reg_sel   = data[1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (sample_queue.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(logic [31:0] st, logic [23:0] lim, logic [1:0] sel, int n_items,
                           bit press);
    int           sent;
    int           len;
    logic [15:0]  fr;
    tone_result_t none;
    sent = 0;
    none = '0;
    wait_drained();
    write_reg(htg_pkg::REG_PHASE_STEP, st);
    write_reg(htg_pkg::REG_FRAME_LIMIT, {8'd0, lim});
    write_reg(htg_pkg::REG_CHANNEL_SELECT, {30'd0, sel});
    cfg_ch.valid <= 1'b0;
    if (press) hold_request = 1'b1;
    while (sent < n_items) begin
      if ($urandom_range(99) < 10) begin
        // stray tick, start or not, anywhere in a buffer
        send_tick(1'($urandom_range(1)), 16'($urandom), 1'b0, none);
        sent++;
      end else begin
        case ($urandom_range(9))
          0:       fr = 16'h0000;
          1:       fr = 16'hFFFF;
          2, 3:    fr = 16'($urandom);
          default: fr = 16'($urandom_range(1, 64));
        endcase
        if (fr != 0 && fr <= 40 && $urandom_range(3) != 0) len = fr;
        else len = $urandom_range(1, 40);
        send_tick(1'b1, fr, 1'b0, none);
        for (int i = 1; i < len; i++) send_tick(1'b0, 16'($urandom), 1'b0, none);
        sent += len;
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(gaps_on && $urandom_range(99) < 8);
    end
  end

  always @(posedge clk) begin
    tone_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (sample_queue.size() == 0) begin
        flag_error($sformatf("unexpected result value=%0d silent=%0b right=%0b",
                             out_ch.sample_value, out_ch.silent, out_ch.right_slot));
      end else begin
        want = sample_queue.pop_front();
        if (out_ch.sample_value !== want.value || out_ch.silent !== want.silent ||
            out_ch.right_slot !== want.right)
          flag_error($sformatf("value exp %0d got %0d, silent exp %0b got %0b, right exp %0b got %0b",
                               want.value, out_ch.sample_value, want.silent, out_ch.silent,
                               want.right, out_ch.right_slot));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t    row;
    logic [31:0]  st;
    logic [23:0]  lim;
    rst                 <= 1'b1;
    in_ch.valid         <= 1'b0;
    in_ch.buffer_start  <= 1'b0;
    in_ch.buffer_frames <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.reg_index    <= '0;
    cfg_ch.reg_data     <= '0;

    build_sine_lut();
    tone_cnt   = 0;
    tone_phase = '0;
    tone_muted = 1'b0;
    reg_step   = htg_pkg::PHASE_STEP_RST;
    reg_limit  = htg_pkg::FRAME_LIMIT_RST;
    reg_sel    = htg_pkg::CH_LEFT;

    // From reset: audible at phase zero, then a zero-length buffer reloads phase zero
    dir_rows.push_back(known_row(1'b0, 16'h0000, 16'sd0, 1'b0, 1'b0));
    dir_rows.push_back(tick_row(1'b0, 16'hFFFF));
    dir_rows.push_back(known_row(1'b1, 16'h0000, 16'sd0, 1'b0, 1'b0));
    dir_rows.push_back(tick_row(1'b1, 16'hFFFF));
    dir_rows.push_back(tick_row(1'b0, 16'h0000));
    dir_rows.push_back(tick_row(1'b0, 16'h1234));
    // Count now past the default limit: buffer goes silent
    dir_rows.push_back(known_row(1'b1, 16'h0001, 16'sd0, 1'b1, 1'b0));
    dir_rows.push_back(known_row(1'b0, 16'hFFFF, 16'sd0, 1'b1, 1'b0));
    dir_rows.push_back(reg_row(htg_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF));
    dir_rows.push_back(reg_row(htg_pkg::REG_FRAME_LIMIT, 32'h00FF_FFFF));
    dir_rows.push_back(reg_row(htg_pkg::REG_CHANNEL_SELECT, {30'd0, htg_pkg::CH_RIGHT}));
    // Silence holds until the next buffer start
    dir_rows.push_back(known_row(1'b0, 16'h0000, 16'sd0, 1'b1, 1'b1));
    dir_rows.push_back(tick_row(1'b1, 16'hFFFF));
    dir_rows.push_back(tick_row(1'b0, 16'h0000));
    dir_rows.push_back(tick_row(1'b0, 16'hAAAA));
    dir_rows.push_back(tick_row(1'b1, 16'h5555));
    dir_rows.push_back(tick_row(1'b0, 16'h0000));
    dir_rows.push_back(reg_row(htg_pkg::REG_PHASE_STEP, 32'h0000_0000));
    dir_rows.push_back(reg_row(htg_pkg::REG_FRAME_LIMIT, 32'h0000_0000));
    dir_rows.push_back(reg_row(htg_pkg::REG_CHANNEL_SELECT, 32'd0));
    dir_rows.push_back(tick_row(1'b0, 16'h0000));
    dir_rows.push_back(known_row(1'b1, 16'h8000, 16'sd0, 1'b1, 1'b0));
    dir_rows.push_back(known_row(1'b0, 16'h7FFF, 16'sd0, 1'b1, 1'b0));
    dir_rows.push_back(reg_row(htg_pkg::REG_CHANNEL_SELECT, 32'd3));
    dir_rows.push_back(known_row(1'b1, 16'h0000, 16'sd0, 1'b1, 1'b0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < dir_rows.size(); i++) begin
      row = dir_rows[i];
      if (row.kind == ROW_REG) begin
        if (i == 0 || dir_rows[i-1].kind != ROW_REG) wait_drained();
        write_reg(row.reg_idx, row.reg_data);
        if (i + 1 == dir_rows.size() || dir_rows[i+1].kind != ROW_REG) cfg_ch.valid <= 1'b0;
      end else begin
        send_tick(row.start, row.frames, row.known, row.want);
        if (i + 1 == dir_rows.size() || dir_rows[i+1].kind != ROW_TICK) in_ch.valid <= 1'b0;
      end
    end

    // No idling on either side, and one long receiver hold-off to back up the input
    gaps_on = 1'b0;
    run_phase(htg_pkg::PHASE_STEP_RST, 24'hFF_FFFF, htg_pkg::CH_LEFT, PHASE_ITEMS, 1'b1);
    gaps_on = 1'b1;
    run_phase(32'hFFFF_FFFF, 24'($urandom_range(0, 2000000)), htg_pkg::CH_RIGHT,
              PHASE_ITEMS, 1'b0);
    run_phase(32'd1, 24'd0, 2'd3, PHASE_ITEMS, 1'b0);
    for (int p = 0; p < 5; p++) begin
      case ($urandom_range(3))
        0:       st = 32'd0;
        1:       st = 32'hFFFF_FFFF;
        default: st = $urandom;
      endcase
      // sometimes place the limit near the running count so both sides of it get hit
      case ($urandom_range(3))
        0:       lim = 24'd0;
        1:       lim = 24'hFF_FFFF;
        2:       lim = 24'(tone_cnt + 64'($urandom_range(0, 100000)));
        default: lim = 24'($urandom);
      endcase
      run_phase(st, lim, 2'($urandom_range(3)), PHASE_ITEMS, 1'b0);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && sample_queue.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
src/htg_pkg.sv
src/htg_if.sv
src/htg_front.sv
src/htg_queue.sv
src/htg_back.sv
src/harmonic_tone_generator.sv
dv/harmonic_tone_generator_test.sv
